>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion helpers shared by the rtl, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define MWM_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds at every edge where the antecedent holds
`define MWM_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/mwm_pkg.sv
// ----------------------------------------------------------------------------
// mwm_pkg
// widths, wheel indices and stage payload types of the mecanum wheel mixer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mwm_pkg;

  localparam int CMD_W   = 16;  // velocity command field
  localparam int SUM_W   = 18;  // signed sum of three commands
  localparam int MAG_W   = 17;  // magnitude of a wheel sum
  localparam int LIM_W   = 15;  // speed limit register
  localparam int PROD_W  = 32;  // magnitude times limit
  localparam int QUO_W   = 15;  // scaled magnitude, never above the limit
  localparam int OUT_W   = 16;  // wheel result field
  localparam int WHEELS  = 4;

  localparam int FRONT_STAGES = 4;
  localparam int DIV_STEPS    = QUO_W;

  // wheel order, lowest field first
  localparam int WHEEL_FL = 0;
  localparam int WHEEL_FR = 1;
  localparam int WHEEL_RL = 2;
  localparam int WHEEL_RR = 3;

  // one command item, vel_x in the lowest bits
  typedef struct packed {
    logic [CMD_W-1:0] yaw_rate;
    logic [CMD_W-1:0] vel_y;
    logic [CMD_W-1:0] vel_x;
  } mwm_cmd_t;

  // per-item side information that rides along from the peak stage to the output
  typedef struct packed {
    logic [WHEELS-1:0]            neg;
    logic [WHEELS-1:0][MAG_W-1:0] mag;
    logic [MAG_W-1:0]             peak;
    logic                         scale;
    logic                         zero;
  } mwm_info_t;

  typedef struct packed {
    mwm_info_t                     info;
    logic [WHEELS-1:0][PROD_W-1:0] prod;
  } mwm_prod_t;

  // divider stage: partial remainder and a shift word holding the
  // unused dividend bits on top and the quotient bits below
  typedef struct packed {
    mwm_info_t                    info;
    logic [WHEELS-1:0][MAG_W-1:0] rem;
    logic [WHEELS-1:0][QUO_W-1:0] nq;
  } mwm_div_t;

endpackage

>>> rtl/mwm_front.sv
// ----------------------------------------------------------------------------
// mwm_front
// wheel sums, magnitudes, peak search and limit products in four stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mwm_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [mwm_pkg::LIM_W-1:0]        limit,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  mwm_pkg::mwm_cmd_t                up_data,
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output mwm_pkg::mwm_prod_t               dn_data
);
  import mwm_pkg::*;

  typedef struct packed {
    logic [WHEELS-1:0]            neg;
    logic [WHEELS-1:0][MAG_W-1:0] mag;
    logic [MAG_W-1:0]             pk_a;
    logic [MAG_W-1:0]             pk_b;
  } mwm_s1_t;

  logic [FRONT_STAGES-1:0]      v_r;
  logic [FRONT_STAGES-1:0]      rdy;
  logic [FRONT_STAGES-1:0]      src_v;

  logic [WHEELS-1:0][SUM_W-1:0] s0_r, s0_nxt;
  mwm_s1_t                      s1_r, s1_nxt;
  mwm_info_t                    s2_r, s2_nxt;
  mwm_prod_t                    s3_r, s3_nxt;

  // a stage can load unless it and everything after it is full and stalled
  for (genvar k = 0; k < FRONT_STAGES; k++) begin : g_rdy
    localparam logic [FRONT_STAGES-1:0] HI =
      ~((FRONT_STAGES'(1) << k) - FRONT_STAGES'(1));
    assign rdy[k] = dn_ready || ((v_r & HI) != HI);
  end

  assign src_v    = {v_r[FRONT_STAGES-2:0], up_valid};
  assign up_ready = rdy[0];
  assign dn_valid = v_r[FRONT_STAGES-1];
  assign dn_data  = s3_r;

  // stage 0: x-type wheel sums at full width
  always_comb begin
    logic signed [SUM_W-1:0] vx, vy, wz;
    vx = SUM_W'($signed(up_data.vel_x));
    vy = SUM_W'($signed(up_data.vel_y));
    wz = SUM_W'($signed(up_data.yaw_rate));
    s0_nxt[WHEEL_FL] = vy + vx + wz;
    s0_nxt[WHEEL_FR] = vy - vx - wz;
    s0_nxt[WHEEL_RL] = vy - vx + wz;
    s0_nxt[WHEEL_RR] = vy + vx - wz;
  end

  // stage 1: sign, magnitude and pairwise max
  always_comb begin
    logic [SUM_W-1:0] abs_v;
    for (int i = 0; i < WHEELS; i++) begin
      s1_nxt.neg[i] = s0_r[i][SUM_W-1];
      abs_v         = s0_r[i][SUM_W-1] ? (~s0_r[i] + SUM_W'(1)) : s0_r[i];
      s1_nxt.mag[i] = abs_v[MAG_W-1:0];
    end
    s1_nxt.pk_a = (s1_nxt.mag[0] > s1_nxt.mag[1]) ? s1_nxt.mag[0] : s1_nxt.mag[1];
    s1_nxt.pk_b = (s1_nxt.mag[2] > s1_nxt.mag[3]) ? s1_nxt.mag[2] : s1_nxt.mag[3];
  end

  // stage 2: peak and the scale decision
  always_comb begin
    s2_nxt.neg   = s1_r.neg;
    s2_nxt.mag   = s1_r.mag;
    s2_nxt.peak  = (s1_r.pk_a > s1_r.pk_b) ? s1_r.pk_a : s1_r.pk_b;
    s2_nxt.zero  = (limit == '0);
    s2_nxt.scale = !s2_nxt.zero && (s2_nxt.peak > MAG_W'(limit));
  end

  // stage 3: magnitude times limit, the dividend of each wheel
  always_comb begin
    s3_nxt.info = s2_r;
    for (int i = 0; i < WHEELS; i++) begin
      s3_nxt.prod[i] = PROD_W'(s2_r.mag[i]) * PROD_W'(limit);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < FRONT_STAGES; k++) begin
        if (rdy[k]) v_r[k] <= src_v[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && src_v[0]) s0_r <= s0_nxt;
    if (rdy[1] && src_v[1]) s1_r <= s1_nxt;
    if (rdy[2] && src_v[2]) s2_r <= s2_nxt;
    if (rdy[3] && src_v[3]) s3_r <= s3_nxt;
  end

endmodule

>>> rtl/mwm_divider.sv
// ----------------------------------------------------------------------------
// mwm_divider
// restoring divide of the four limit products by the peak, one bit a stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mwm_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  mwm_pkg::mwm_prod_t  up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output mwm_pkg::mwm_div_t   dn_data
);
  import mwm_pkg::*;

  // one quotient bit: shift in the next dividend bit, subtract if it fits
  function automatic mwm_div_t div_step(input mwm_div_t d);
    mwm_div_t       o;
    logic [MAG_W:0] t;
    logic           ge;
    o = d;
    for (int i = 0; i < WHEELS; i++) begin
      t  = {d.rem[i], d.nq[i][QUO_W-1]};
      ge = (t >= {1'b0, d.info.peak});
      o.rem[i] = ge ? MAG_W'(t - {1'b0, d.info.peak}) : t[MAG_W-1:0];
      o.nq[i]  = {d.nq[i][QUO_W-2:0], ge};
    end
    return o;
  endfunction

  logic [DIV_STEPS-1:0] v_r;
  logic [DIV_STEPS-1:0] rdy;
  logic [DIV_STEPS-1:0] src_v;
  mwm_div_t             st_r   [DIV_STEPS];
  mwm_div_t             st_nxt [DIV_STEPS];
  mwm_div_t             entry;

  // quotient is below 2**QUO_W, so the top dividend bits start as remainder
  always_comb begin
    entry.info = up_data.info;
    for (int i = 0; i < WHEELS; i++) begin
      entry.rem[i] = up_data.prod[i][PROD_W-1:QUO_W];
      entry.nq[i]  = up_data.prod[i][QUO_W-1:0];
    end
  end

  assign src_v    = {v_r[DIV_STEPS-2:0], up_valid};
  assign up_ready = rdy[0];
  assign dn_valid = v_r[DIV_STEPS-1];
  assign dn_data  = st_r[DIV_STEPS-1];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
    localparam logic [DIV_STEPS-1:0] HI =
      ~((DIV_STEPS'(1) << k) - DIV_STEPS'(1));
    assign rdy[k] = dn_ready || ((v_r & HI) != HI);

    if (k == 0) begin : g_first
      assign st_nxt[k] = div_step(entry);
    end else begin : g_next
      assign st_nxt[k] = div_step(st_r[k-1]);
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_v[k]) st_r[k] <= st_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        if (rdy[k]) v_r[k] <= src_v[k];
      end
    end
  end

endmodule

>>> rtl/mecanum_wheel_mixer.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer
// x-type mecanum inverse kinematics with proportional normalization
// ----------------------------------------------------------------------------
// usage
//   cfg_valid/cfg_data write the 15-bit speed limit; cfg_ready is always high.
//   write it only while no item is in flight. a limit of zero forces every
//   wheel result to zero.
//   in_* carries one velocity command item (vel_x, vel_y, yaw_rate).
//   out_* carries one item of four wheel targets for every command item.
//   when the largest wheel magnitude exceeds the limit, each wheel becomes
//   wheel * limit / peak, truncated toward zero; otherwise it passes as is.
// timing
//   an item that is taken passes through four front stages (sums, magnitudes,
//   peak, limit products), fifteen divide stages (one quotient bit each, set
//   by the 15-bit quotient width) and the output register. one item per cycle
//   sustained while the output is not stalled, up to 20 items in flight.
// reset and stall
//   reset empties the pipeline and sets the limit to zero. a stalled output
//   holds its item; earlier stages keep filling their bubbles, and in_tready
//   drops only when every stage holds an item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mecanum_wheel_mixer (
  input  logic                                         clk,
  input  logic                                         rst_n,
  // speed limit write
  input  logic                                         cfg_valid,
  output logic                                         cfg_ready,
  input  logic [mwm_pkg::LIM_W-1:0]                    cfg_data,
  // command items
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  input  logic [3*mwm_pkg::CMD_W-1:0]                  in_tdata,  // vel_x, vel_y, yaw_rate
  // wheel items
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  output logic [mwm_pkg::WHEELS*mwm_pkg::OUT_W-1:0]    out_tdata  // front_left_speed,
                                                                  // front_right_speed,
                                                                  // rear_left_speed,
                                                                  // rear_right_speed
);
  import mwm_pkg::*;

  logic [LIM_W-1:0]             limit_r;

  mwm_prod_t                    prod_data;
  logic                         prod_valid, prod_ready;
  mwm_div_t                     div_data;
  logic                         div_valid, div_ready;

  logic                         out_valid_r;
  logic [WHEELS-1:0][OUT_W-1:0] res_r, res_nxt;

  // limit register, writes always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else if (cfg_valid) begin
      limit_r <= cfg_data;
    end
  end

  mwm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .limit    (limit_r),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_data  (mwm_cmd_t'(in_tdata)),
    .dn_valid (prod_valid),
    .dn_ready (prod_ready),
    .dn_data  (prod_data)
  );

  mwm_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (prod_valid),
    .up_ready (prod_ready),
    .up_data  (prod_data),
    .dn_valid (div_valid),
    .dn_ready (div_ready),
    .dn_data  (div_data)
  );

  // output register: pick scaled or unscaled magnitude, restore sign.
  // a scaled wheel is already within the limit, and so is an unscaled one
  // whenever the limit is nonzero, so the clamp reduces to the zero case
  always_comb begin
    logic [OUT_W-1:0] m;
    for (int i = 0; i < WHEELS; i++) begin
      m = div_data.info.scale ? OUT_W'(div_data.nq[i])
                              : div_data.info.mag[i][OUT_W-1:0];
      if (div_data.info.zero) begin
        res_nxt[i] = '0;
      end else if (div_data.info.neg[i]) begin
        res_nxt[i] = ~m + OUT_W'(1);
      end else begin
        res_nxt[i] = m;
      end
    end
  end

  assign div_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div_ready) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ready && div_valid) res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

  // input backs up only when the whole pipeline is full behind a stalled output
  `MWM_ASSERT_IMPLY(a_full_stall, !in_tready, out_tvalid && !out_tready,
                    "input stalled with room in pipe")

  // scaling is only chosen with a nonzero limit and a nonzero peak
  `MWM_ASSERT_IMPLY(a_scale_peak, div_valid && div_data.info.scale,
                    (div_data.info.peak != '0) && !div_data.info.zero,
                    "scale with zero peak or limit")

  // every wheel stays within plus or minus 32767
  `MWM_ASSERT_IMPLY(a_out_range, out_tvalid,
                    (res_r[WHEEL_FL] != 16'h8000) && (res_r[WHEEL_FR] != 16'h8000) &&
                    (res_r[WHEEL_RL] != 16'h8000) && (res_r[WHEEL_RR] != 16'h8000),
                    "wheel result out of range")

endmodule

>>> tb/mecanum_wheel_mixer_test.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer_test
// drives velocity command items through the wheel mixer, predicts the four
// wheel targets of each item from the current speed limit and checks every
// wheel item in order, under random idling on both sides and one long stall
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mecanum_wheel_mixer_test;

  import mwm_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int HOLD_CYCLES   = 300;   // long output stall, fills the pipeline
  localparam int HOLD_AT       = 400;   // results seen before the long stall
  localparam int PHASE_ITEMS   = 190;
  localparam int SETTLE_CYCLES = 30;    // a margin beyond the pipeline latency

  // wheel item, front left in the lowest bits
  typedef logic [WHEELS-1:0][OUT_W-1:0] wheels_t;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of the limit and the wheel items still owed
  // --------------------------------------------------------------------------
  class wheel_scoreboard;
    int unsigned speed_limit;
    wheels_t     owed_wheels[$];
    int          errors;
    string       wheel_name[WHEELS];

    function new();
      speed_limit = 0;
      errors      = 0;
      wheel_name  = '{"front_left_speed", "front_right_speed",
                      "rear_left_speed", "rear_right_speed"};
    endfunction

    // x-type mixing, proportional scaling, then clamp to +-limit
    function wheels_t mix_command(mwm_cmd_t c);
      longint  vx, vy, wz, lim, peak, m, v;
      longint  w[WHEELS];
      wheels_t r;
      vx = longint'($signed(c.vel_x));
      vy = longint'($signed(c.vel_y));
      wz = longint'($signed(c.yaw_rate));
      lim = longint'(speed_limit);
      w[WHEEL_FL] = vy + vx + wz;
      w[WHEEL_FR] = vy - vx - wz;
      w[WHEEL_RL] = vy - vx + wz;
      w[WHEEL_RR] = vy + vx - wz;
      peak = 0;
      for (int i = 0; i < WHEELS; i++) begin
        m = (w[i] < 0) ? -w[i] : w[i];
        if (m > peak) peak = m;
      end
      for (int i = 0; i < WHEELS; i++) begin
        v = w[i];
        // sv division truncates toward zero
        if (lim > 0 && peak > lim) v = (v * lim) / peak;
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        r[i] = v[OUT_W-1:0];
      end
      return r;
    endfunction

    function void note_command(mwm_cmd_t c);
      owed_wheels.push_back(mix_command(c));
    endfunction

    function void check_wheels(wheels_t got);
      wheels_t want;
      if (owed_wheels.size() == 0) begin
        $error("wheel item %h with none expected", got);
        errors++;
        return;
      end
      want = owed_wheels.pop_front();
      for (int i = 0; i < WHEELS; i++) begin
        if (got[i] !== want[i]) begin
          $error("%s: expected %0d, actual %0d", wheel_name[i],
                 $signed(want[i]), $signed(got[i]));
          errors++;
        end
      end
    endfunction

    function int pending();
      return owed_wheels.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block under test
  // --------------------------------------------------------------------------
  logic                      clk;
  logic                      rst_n;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [LIM_W-1:0]          cfg_data;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [3*CMD_W-1:0]        in_tdata;   // vel_x, vel_y, yaw_rate
  logic                      out_tvalid;
  logic                      out_tready;
  logic [WHEELS*OUT_W-1:0]   out_tdata;  // front_left_speed, front_right_speed,
                                         // rear_left_speed, rear_right_speed

  mecanum_wheel_mixer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  wheel_scoreboard board = new();

  int  cycle_count  = 0;
  bit  sink_holding = 1'b0;   // set while the long output stall runs
  int  send_quiet   = 0;      // items left in a no-idle stretch, sender side
  int  sink_quiet   = 0;      // same on the receiving side

  // --------------------------------------------------------------------------
  // clock, watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // random per-item wait, with occasional stretches of no idling at all
  function automatic int pick_wait(ref int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet_left = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // --------------------------------------------------------------------------
  // receiving side: checks each accepted wheel item, stalls at random
  // --------------------------------------------------------------------------
  initial begin : sink
    int  stall_left;
    int  seen;
    bit  held_once;
    stall_left = 0;
    seen       = 0;
    held_once  = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      // values sampled here are the ones the edge saw
      if (out_tvalid && out_tready) begin
        board.check_wheels(out_tdata);
        seen++;
        if (seen == HOLD_AT && !held_once) begin
          // long hold-off while the sender keeps offering items
          held_once    = 1'b1;
          sink_holding = 1'b1;
          stall_left   = HOLD_CYCLES;
        end else begin
          stall_left = pick_wait(sink_quiet);
        end
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready   <= 1'b1;
        sink_holding = 1'b0;
      end
      @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // sending side
  // --------------------------------------------------------------------------

  // offer one command item after its gap; valid stays high across back-to-back items
  task automatic send_command(input logic [CMD_W-1:0] vx, input logic [CMD_W-1:0] vy,
                              input logic [CMD_W-1:0] wz);
    int       gap;
    mwm_cmd_t c;
    gap = sink_holding ? 0 : pick_wait(send_quiet);
    c.vel_x    = vx;
    c.vel_y    = vy;
    c.yaw_rate = wz;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    board.note_command(c);
  endtask

  // stop offering and let every owed wheel item come out
  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // limit is written only with the pipeline empty
  task automatic write_speed_limit(input int unsigned limit);
    drain_pipeline();
    cfg_valid <= 1'b1;
    cfg_data  <= limit[LIM_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.speed_limit = limit & ((1 << LIM_W) - 1);
  endtask

  function automatic logic [CMD_W-1:0] extreme_value();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'h0001;
    endcase
  endfunction

  // a span small enough that no wheel sum can pass the limit
  function automatic logic [CMD_W-1:0] within_value(input int unsigned limit);
    int span;
    span = int'(limit) / 3;
    return CMD_W'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic send_random(input int unsigned limit);
    int mode;
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1, 2, 3, 4:
        send_command(CMD_W'($urandom()), CMD_W'($urandom()), CMD_W'($urandom()));
      5, 6:
        send_command(within_value(limit), within_value(limit), within_value(limit));
      7:
        send_command(extreme_value(), extreme_value(), extreme_value());
      8: begin
        // a single axis moving
        case ($urandom_range(0, 2))
          0:       send_command(CMD_W'($urandom()), 16'h0, 16'h0);
          1:       send_command(16'h0, CMD_W'($urandom()), 16'h0);
          default: send_command(16'h0, 16'h0, CMD_W'($urandom()));
        endcase
      end
      default:
        send_command(CMD_W'(int'($urandom_range(0, 1023)) - 512),
                     CMD_W'(int'($urandom_range(0, 1023)) - 512),
                     CMD_W'(int'($urandom_range(0, 1023)) - 512));
    endcase
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    int unsigned limits[10];
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // limit still zero from reset: everything clamps to zero
    send_command(16'h7fff, 16'h7fff, 16'h7fff);
    send_command(16'h8000, 16'h1234, 16'hffff);

    // widest limit, field extremes, every sum at its edge
    write_speed_limit(32767);
    send_command(16'h7fff, 16'h7fff, 16'h7fff);
    send_command(16'h8000, 16'h8000, 16'h8000);
    send_command(16'h7fff, 16'h8000, 16'h7fff);
    send_command(16'h8000, 16'h7fff, 16'h8000);
    send_command(16'h0000, 16'h8000, 16'h0000);
    send_command(16'h0000, 16'h0000, 16'h0000);
    send_command(16'hffff, 16'h0001, 16'hffff);
    send_command(16'h4000, 16'h3fff, 16'h0000);

    // smallest positive limit
    write_speed_limit(1);
    send_command(16'h0000, 16'h0000, 16'h0000);
    send_command(16'h0000, 16'h0001, 16'h0000);
    send_command(16'h0003, 16'hfffe, 16'h0005);
    send_command(16'h7fff, 16'h8000, 16'h0001);

    // peak within the limit passes unscaled, peak just above it scales
    write_speed_limit(100);
    send_command(16'd10, 16'd20, 16'd30);
    send_command(16'hfff6, 16'hffec, 16'hffe2);
    send_command(16'd0, 16'd100, 16'd0);
    send_command(16'd0, 16'd101, 16'd0);
    send_command(16'd34, 16'd33, 16'd34);

    // random phases over a spread of limits, extremes among them
    limits[0] = 32767;
    limits[1] = $urandom_range(0, 32767);
    limits[2] = 1;
    limits[3] = $urandom_range(2, 200);
    limits[4] = 0;
    limits[5] = $urandom_range(0, 32767);
    limits[6] = 16384;
    limits[7] = $urandom_range(1000, 20000);
    limits[8] = 21845;
    limits[9] = $urandom_range(0, 32767);
    for (int p = 0; p < 10; p++) begin
      write_speed_limit(limits[p]);
      repeat (PHASE_ITEMS) send_random(limits[p]);
    end

    drain_pipeline();
    // catch any stray wheel item past the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
